// File: rtl/core/tbc_pkg.sv
`timescale 1ns / 1ps
package tbc_pkg;

	// Field widths.
	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 28;
	localparam int OUT_W      = 32;

	// Datapath widths that follow from the field widths.
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int DET_W  = PROD_W + 1;
	localparam int MAG_W  = 2 * COORD_BITS + 1;
	localparam int QW     = OUT_W + 2;
	localparam int QS_W   = QW + 2;
	localparam int STEPS  = MAG_W + FRAC_BITS;

	// Queue between the front and back halves.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Clipping limits of the output format.
	localparam logic [QS_W-1:0] OUT_MAX_X = {{(QS_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic [QS_W-1:0] OUT_MIN_X = {{(QS_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
	localparam logic [OUT_W-1:0] OUT_MAX_V = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN_V = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [OUT_W-1:0] ONE_Q = OUT_W'(1) << FRAC_BITS;

	// One word handed from the front to the back: magnitudes and signs
	// after the determinant sign has been folded into the numerators.
	typedef struct packed {
		logic             degen;
		logic [MAG_W-1:0] d_mag;
		logic [2:0]       neg;
		logic [MAG_W-1:0] n1_mag;
		logic [MAG_W-1:0] n2_mag;
		logic [MAG_W-1:0] n3_mag;
	} tbc_job_t;

	// Side data that travels next to the divider lanes.
	typedef struct packed {
		logic             degen;
		logic [MAG_W-1:0] d_mag;
		logic [2:0]       neg;
	} tbc_side_t;

	// One step of restoring division.
	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [QW-1:0]    q;
		logic             big;
	} tbc_dstep_t;

	typedef struct packed {
		logic             sat;
		logic [OUT_W-1:0] val;
	} tbc_sat_t;

	typedef struct packed {
		logic [OUT_W-1:0] first;
		logic [OUT_W-1:0] second;
		logic [OUT_W-1:0] third;
		logic             degenerate;
		logic             saturated;
	} tbc_res_t;

	// Shift one dividend bit into the remainder and try a subtract.
	// Quotient bits that leave the top of the register set the big flag.
	function automatic tbc_dstep_t tbc_div_step(input logic [MAG_W-1:0] rem,
		input logic [QW-1:0] q, input logic big, input logic bin,
		input logic [MAG_W-1:0] d);
		logic [MAG_W:0] sh;
		logic [MAG_W:0] diff;
		tbc_dstep_t     r;
		sh    = {rem, bin};
		diff  = sh - {1'b0, d};
		r.big = big | q[QW-1];
		if (sh >= {1'b0, d}) begin
			r.rem = diff[MAG_W-1:0];
			r.q   = {q[QW-2:0], 1'b1};
		end else begin
			r.rem = sh[MAG_W-1:0];
			r.q   = {q[QW-2:0], 1'b0};
		end
		return r;
	endfunction

	// Magnitude of a signed determinant-sized value.
	function automatic logic [MAG_W-1:0] tbc_abs(input logic [DET_W-1:0] v);
		logic [DET_W-1:0] a;
		a = v[DET_W-1] ? (~v + 1'b1) : v;
		return a[MAG_W-1:0];
	endfunction

	// Clip a weight to the output format.
	function automatic tbc_sat_t tbc_saturate(input logic [QS_W-1:0] v,
		input logic big, input logic neg);
		tbc_sat_t r;
		r.sat = 1'b0;
		r.val = v[OUT_W-1:0];
		if (big) begin
			r.sat = 1'b1;
			r.val = neg ? OUT_MIN_V : OUT_MAX_V;
		end else if ($signed(v) > $signed(OUT_MAX_X)) begin
			r.sat = 1'b1;
			r.val = OUT_MAX_V;
		end else if ($signed(v) < $signed(OUT_MIN_X)) begin
			r.sat = 1'b1;
			r.val = OUT_MIN_V;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/triangle_barycentric_coords.sv
`timescale 1ns / 1ps
// Barycentric coordinates of a point in a 2-D triangle.
// Input channel (in_valid / in_ready) takes one word: the query point and
// the three vertices, signed integers. Output channel (out_valid /
// out_ready) returns one word per input: three weights in signed Q4.28,
// a degenerate flag (zero area, weights zero) and a saturated flag.
// Weights one and two are floor(n * 2^28 / D); weight three makes the
// three add up to exactly one before clipping.
// Throughput is one word per cycle while out_ready stays high. From input
// acceptance to out_valid a word passes four front stages (differences,
// products, determinants), a two-entry queue, a 77-stage restoring divider
// that produces one quotient bit per stage in each of three lanes, two
// correction stages and the output register.
// The divider pipeline and the front each hold as a unit only when their
// last stage is full and cannot move on; bubbles keep filling meanwhile,
// so new words are taken while a result waits in the output register.
// When the receiver stalls long enough, the back and then the front fill
// and in_ready drops. Reset clears all valid bits; no result is pending.
module triangle_barycentric_coords (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] point_y,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] vertex1_x,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] vertex1_y,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] vertex2_x,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] vertex2_y,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] vertex3_x,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] vertex3_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [tbc_pkg::OUT_W-1:0]      first_coord,
	output logic signed [tbc_pkg::OUT_W-1:0]      second_coord,
	output logic signed [tbc_pkg::OUT_W-1:0]      third_coord,
	output logic                                  degenerate,
	output logic                                  saturated
);
	import tbc_pkg::*;

	logic     f_valid, f_ready;
	tbc_job_t f_job;
	logic     b_valid, b_ready;
	tbc_job_t b_job;
	tbc_res_t res;

	// Front: vectors, cross products and sign folding.
	tbc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y),
		.vertex1_x(vertex1_x), .vertex1_y(vertex1_y),
		.vertex2_x(vertex2_x), .vertex2_y(vertex2_y),
		.vertex3_x(vertex3_x), .vertex3_y(vertex3_y),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	// Queue between the halves.
	tbc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready), .push_data(f_job),
		.pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_job)
	);

	// Back: division, correction and clipping.
	tbc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(b_valid), .job_ready(b_ready), .job(b_job),
		.out_valid(out_valid), .out_ready(out_ready), .res(res)
	);

	assign first_coord  = res.first;
	assign second_coord = res.second;
	assign third_coord  = res.third;
	assign degenerate   = res.degenerate;
	assign saturated    = res.saturated;

	// A zero-area triangle gives all-zero weights and no clipping.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |->
			first_coord == '0 && second_coord == '0 && third_coord == '0 && !saturated)
		else $error("degenerate result with nonzero fields");

	// Unclipped weights add up to exactly one.
	a_sum_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate && !saturated |->
			OUT_W'(first_coord + second_coord + third_coord) == ONE_Q)
		else $error("weights do not sum to one");

	// The front only stalls when the queue toward the back is full.
	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> f_valid && !f_ready)
		else $error("front stalled with room in the queue");

endmodule

// File: rtl/core/tbc_fifo.sv
`timescale 1ns / 1ps
module tbc_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  tbc_pkg::tbc_job_t  push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output tbc_pkg::tbc_job_t  pop_data
);
	import tbc_pkg::*;

	tbc_job_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                push;
	logic                pop;

	// Handshake on both sides of the queue.
	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/core/tbc_front.sv
`timescale 1ns / 1ps
module tbc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] point_y,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] vertex1_x,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] vertex1_y,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] vertex2_x,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] vertex2_y,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] vertex3_x,
	input  logic signed [tbc_pkg::COORD_BITS-1:0] vertex3_y,
	output logic                                job_valid,
	input  logic                                job_ready,
	output tbc_pkg::tbc_job_t                   job
);
	import tbc_pkg::*;

	logic                     en;
	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [DIFF_W-1:0] dxa_s1, dya_s1, dxb_s1, dyb_s1, dxp_s1, dyp_s1;
	logic signed [PROD_W-1:0] pd0_s2, pd1_s2, pn10_s2, pn11_s2, pn20_s2, pn21_s2;
	logic signed [DET_W-1:0]  d_s3, n1_s3, n2_s3;
	logic signed [DET_W-1:0]  d_s4, n1_s4, n2_s4, n3_s4;

	// The whole front moves together; it holds only when its last stage
	// is full and the queue has no room.
	assign en        = !v_s4 || job_ready;
	assign in_ready  = en;
	assign job_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: edge vectors relative to the third vertex.
	// Stage 2: the six cross products.
	// Stage 3: determinant and the first two sub-determinants.
	// Stage 4: third sub-determinant, which is what the other two leave of D.
	always_ff @(posedge clk) begin
		if (en) begin
			dxa_s1  <= DIFF_W'(vertex1_x) - DIFF_W'(vertex3_x);
			dya_s1  <= DIFF_W'(vertex1_y) - DIFF_W'(vertex3_y);
			dxb_s1  <= DIFF_W'(vertex2_x) - DIFF_W'(vertex3_x);
			dyb_s1  <= DIFF_W'(vertex2_y) - DIFF_W'(vertex3_y);
			dxp_s1  <= DIFF_W'(point_x) - DIFF_W'(vertex3_x);
			dyp_s1  <= DIFF_W'(point_y) - DIFF_W'(vertex3_y);

			pd0_s2  <= dxa_s1 * dyb_s1;
			pd1_s2  <= dxb_s1 * dya_s1;
			pn10_s2 <= dxp_s1 * dyb_s1;
			pn11_s2 <= dxb_s1 * dyp_s1;
			pn20_s2 <= dxa_s1 * dyp_s1;
			pn21_s2 <= dxp_s1 * dya_s1;

			d_s3    <= DET_W'(pd0_s2) - DET_W'(pd1_s2);
			n1_s3   <= DET_W'(pn10_s2) - DET_W'(pn11_s2);
			n2_s3   <= DET_W'(pn20_s2) - DET_W'(pn21_s2);

			d_s4    <= d_s3;
			n1_s4   <= n1_s3;
			n2_s4   <= n2_s3;
			n3_s4   <= d_s3 - n1_s3 - n2_s3;
		end
	end

	// Fold the sign of D into each numerator and hand over magnitudes.
	always_comb begin
		job.degen  = (d_s4 == '0);
		job.d_mag  = tbc_abs(d_s4);
		job.neg[0] = n1_s4[DET_W-1] ^ d_s4[DET_W-1];
		job.neg[1] = n2_s4[DET_W-1] ^ d_s4[DET_W-1];
		job.neg[2] = n3_s4[DET_W-1] ^ d_s4[DET_W-1];
		job.n1_mag = tbc_abs(n1_s4);
		job.n2_mag = tbc_abs(n2_s4);
		job.n3_mag = tbc_abs(n3_s4);
	end

endmodule

// File: rtl/core/tbc_div.sv
`timescale 1ns / 1ps
module tbc_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [tbc_pkg::MAG_W-1:0]    mag,
	input  logic [tbc_pkg::MAG_W-1:0]    d_in,
	input  logic [tbc_pkg::MAG_W-1:0]    d_pipe [tbc_pkg::STEPS],
	output logic [tbc_pkg::QW-1:0]       q,
	output logic                         big,
	output logic [tbc_pkg::MAG_W-1:0]    rem
);
	import tbc_pkg::*;

	// One quotient bit per stage; the dividend is mag followed by
	// FRAC_BITS zero bits, so mag only travels through the first stages.
	tbc_dstep_t       st_s  [STEPS];
	logic [MAG_W-1:0] mag_s [MAG_W-1];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					st_s[k] <= tbc_div_step('0, '0, 1'b0, mag[MAG_W-1], d_in);
				end
			end
		end else if (k < MAG_W) begin : g_mid
			always_ff @(posedge clk) begin
				if (en) begin
					st_s[k] <= tbc_div_step(st_s[k-1].rem, st_s[k-1].q, st_s[k-1].big,
						mag_s[k-1][MAG_W-1-k], d_pipe[k-1]);
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (en) begin
					st_s[k] <= tbc_div_step(st_s[k-1].rem, st_s[k-1].q, st_s[k-1].big,
						1'b0, d_pipe[k-1]);
				end
			end
		end

		if (k < MAG_W - 1) begin : g_mag
			if (k == 0) begin : g_mag_first
				always_ff @(posedge clk) begin
					if (en) begin
						mag_s[k] <= mag;
					end
				end
			end else begin : g_mag_next
				always_ff @(posedge clk) begin
					if (en) begin
						mag_s[k] <= mag_s[k-1];
					end
				end
			end
		end
	end

	assign q   = st_s[STEPS-1].q;
	assign big = st_s[STEPS-1].big;
	assign rem = st_s[STEPS-1].rem;

endmodule

// File: rtl/core/tbc_back.sv
`timescale 1ns / 1ps
module tbc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  tbc_pkg::tbc_job_t job,
	output logic              out_valid,
	input  logic              out_ready,
	output tbc_pkg::tbc_res_t res
);
	import tbc_pkg::*;

	logic             en;
	logic             vld_s [STEPS];
	tbc_side_t        sb_s  [STEPS];
	logic [MAG_W-1:0] d_pipe [STEPS];
	logic [QW-1:0]    dq1, dq2, dq3;
	logic             dbig1, dbig2, dbig3;
	logic [MAG_W-1:0] drem1, drem2, drem3;

	// Post stages after the divider.
	logic             post_v_s1, post_v_s2;
	tbc_side_t        post_sb_s1, post_sb_s2;
	logic [QS_W-1:0]  q1_s1, q2_s1, q3_s1, q1_s2, q2_s2, q3_s2;
	logic [2:0]       big_s1, big_s2;
	logic [MAG_W-1:0] r1_s1, r2_s1, r3_s1;
	logic [1:0]       carry_s2;

	logic             out_valid_q;
	tbc_res_t         res_q;
	logic [MAG_W+1:0] rsum;
	logic [MAG_W+1:0] d1x, d2x;
	logic [QS_W-1:0]  q3_fin;
	tbc_sat_t         s1, s2, s3;
	tbc_res_t         res_d;

	// Floor of a negative quotient drops by one when the division left a
	// remainder; the remainder then becomes D minus what was left.
	function automatic logic [QS_W-1:0] fix_q(input logic [QW-1:0] q,
		input logic [MAG_W-1:0] r, input logic neg);
		logic [QS_W-1:0] qm;
		qm = QS_W'(q);
		if (!neg) begin
			return qm;
		end else if (r != '0) begin
			return ~qm;
		end else begin
			return ~qm + 1'b1;
		end
	endfunction

	function automatic logic [MAG_W-1:0] fix_r(input logic [MAG_W-1:0] r,
		input logic [MAG_W-1:0] d, input logic neg);
		return (neg && (r != '0)) ? (d - r) : r;
	endfunction

	// The back holds only when a finished word sits in its last stage and
	// the output register is full and not being drained.
	assign en        = !(post_v_s2 && out_valid_q && !out_ready);
	assign job_ready = en;

	for (genvar k = 0; k < STEPS; k++) begin : g_dpipe
		assign d_pipe[k] = sb_s[k].d_mag;
	end

	tbc_div u_div1 (
		.clk(clk), .en(en), .mag(job.n1_mag), .d_in(job.d_mag), .d_pipe(d_pipe),
		.q(dq1), .big(dbig1), .rem(drem1)
	);
	tbc_div u_div2 (
		.clk(clk), .en(en), .mag(job.n2_mag), .d_in(job.d_mag), .d_pipe(d_pipe),
		.q(dq2), .big(dbig2), .rem(drem2)
	);
	tbc_div u_div3 (
		.clk(clk), .en(en), .mag(job.n3_mag), .d_in(job.d_mag), .d_pipe(d_pipe),
		.q(dq3), .big(dbig3), .rem(drem3)
	);

	// Valid bits of all back stages and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STEPS; i++) begin
				vld_s[i] <= 1'b0;
			end
			post_v_s1   <= 1'b0;
			post_v_s2   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en) begin
				vld_s[0] <= job_valid;
				for (int i = 1; i < STEPS; i++) begin
					vld_s[i] <= vld_s[i-1];
				end
				post_v_s1 <= vld_s[STEPS-1];
				post_v_s2 <= post_v_s1;
			end
			if (post_v_s2 && en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Side data next to the divider lanes.
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0].degen <= job.degen;
			sb_s[0].d_mag <= job.d_mag;
			sb_s[0].neg   <= job.neg;
			for (int i = 1; i < STEPS; i++) begin
				sb_s[i] <= sb_s[i-1];
			end
		end
	end

	// Stage 1 after the divider: turn truncated magnitudes into floor
	// quotients and non-negative remainders.
	always_ff @(posedge clk) begin
		if (en) begin
			post_sb_s1 <= sb_s[STEPS-1];
			big_s1     <= {dbig3, dbig2, dbig1};
			q1_s1      <= fix_q(dq1, drem1, sb_s[STEPS-1].neg[0]);
			q2_s1      <= fix_q(dq2, drem2, sb_s[STEPS-1].neg[1]);
			q3_s1      <= fix_q(dq3, drem3, sb_s[STEPS-1].neg[2]);
			r1_s1      <= fix_r(drem1, sb_s[STEPS-1].d_mag, sb_s[STEPS-1].neg[0]);
			r2_s1      <= fix_r(drem2, sb_s[STEPS-1].d_mag, sb_s[STEPS-1].neg[1]);
			r3_s1      <= fix_r(drem3, sb_s[STEPS-1].d_mag, sb_s[STEPS-1].neg[2]);
		end
	end

	// Stage 2: the three remainders sum to 0, D or 2D; that multiple is
	// what the third weight needs so that the weights add up to one.
	assign rsum = (MAG_W+2)'(r1_s1) + (MAG_W+2)'(r2_s1) + (MAG_W+2)'(r3_s1);
	assign d1x  = (MAG_W+2)'(post_sb_s1.d_mag);
	assign d2x  = {1'b0, post_sb_s1.d_mag, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			post_sb_s2 <= post_sb_s1;
			big_s2     <= big_s1;
			q1_s2      <= q1_s1;
			q2_s2      <= q2_s1;
			q3_s2      <= q3_s1;
			if (rsum >= d2x) begin
				carry_s2 <= 2'd2;
			end else if (rsum >= d1x) begin
				carry_s2 <= 2'd1;
			end else begin
				carry_s2 <= 2'd0;
			end
		end
	end

	// Final correction and clipping into the output register.
	assign q3_fin = q3_s2 + QS_W'(carry_s2);
	assign s1     = tbc_saturate(q1_s2, big_s2[0], post_sb_s2.neg[0]);
	assign s2     = tbc_saturate(q2_s2, big_s2[1], post_sb_s2.neg[1]);
	assign s3     = tbc_saturate(q3_fin, big_s2[2], post_sb_s2.neg[2]);

	always_comb begin
		if (post_sb_s2.degen) begin
			res_d.first      = '0;
			res_d.second     = '0;
			res_d.third      = '0;
			res_d.degenerate = 1'b1;
			res_d.saturated  = 1'b0;
		end else begin
			res_d.first      = s1.val;
			res_d.second     = s2.val;
			res_d.third      = s3.val;
			res_d.degenerate = 1'b0;
			res_d.saturated  = s1.sat | s2.sat | s3.sat;
		end
	end

	always_ff @(posedge clk) begin
		if (post_v_s2 && en) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

// File: test/triangle_barycentric_coords_tb.sv
`timescale 1ns / 1ps
module triangle_barycentric_coords_tb;
	import tbc_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int IDLE_LIMIT  = 3000;
	localparam int TAIL_CYCLES = 200;
	localparam int RANDOM_WORDS = 900;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// One query word as the sender presents it; drain marks a pause point.
	typedef struct {
		coord_t px, py, ax, ay, bx, by, cx, cy;
		bit     drain;
	} query_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	coord_t           point_x, point_y, vertex1_x, vertex1_y;
	coord_t           vertex2_x, vertex2_y, vertex3_x, vertex3_y;
	logic             out_valid;
	logic             out_ready;
	logic signed [OUT_W-1:0] first_coord, second_coord, third_coord;
	logic             degenerate;
	logic             saturated;

	query_t   pending_queries[$];
	tbc_res_t expected_weights[$];
	int       mismatch_count = 0;
	int       words_sent = 0;
	int       words_checked = 0;
	int       degenerate_seen = 0;
	int       saturated_seen = 0;
	bit       sent_last_edge = 0;
	int       idle_cycles = 0;

	triangle_barycentric_coords uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y),
		.vertex1_x(vertex1_x), .vertex1_y(vertex1_y),
		.vertex2_x(vertex2_x), .vertex2_y(vertex2_y),
		.vertex3_x(vertex3_x), .vertex3_y(vertex3_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.first_coord(first_coord), .second_coord(second_coord),
		.third_coord(third_coord), .degenerate(degenerate),
		.saturated(saturated)
	);

	// Free-running clock.
	always begin
		clk = 1'b1;
		#HALF_PERIOD;
		clk = 1'b0;
		#HALF_PERIOD;
	end

	// Exact floor of n * 2^FRAC_BITS / d for positive d, with the remainder.
	function automatic void floor_scaled(input longint n, input longint d,
		output logic signed [127:0] quo, output logic signed [127:0] rem);
		logic signed [127:0] num;
		logic signed [127:0] den;
		num = n;
		den = d;
		num = num <<< FRAC_BITS;
		quo = num / den;
		rem = num - quo * den;
		if (rem < 0) begin
			quo = quo - 1;
			rem = rem + den;
		end
	endfunction

	// Clip one weight to the output range and note any clipping.
	function automatic logic [OUT_W-1:0] clip_weight(input logic signed [127:0] v,
		inout logic sat);
		logic signed [127:0] hi;
		logic signed [127:0] lo;
		hi = 128'sh7FFF_FFFF;
		lo = -128'sh8000_0000;
		if (v > hi) begin
			sat = 1'b1;
			return OUT_MAX_V;
		end
		if (v < lo) begin
			sat = 1'b1;
			return OUT_MIN_V;
		end
		return v[OUT_W-1:0];
	endfunction

	// Barycentric weights of the query point, bit exact.
	function automatic tbc_res_t barycentric_weights(input query_t w);
		longint px, py, ax, ay, bx, by, cx, cy, det, n1, n2, n3;
		logic signed [127:0] q1, q2, q3, r1, r2, r3, corr;
		logic sat;
		tbc_res_t res;
		px = w.px; py = w.py; ax = w.ax; ay = w.ay;
		bx = w.bx; by = w.by; cx = w.cx; cy = w.cy;
		det = (ax - cx) * (by - cy) - (bx - cx) * (ay - cy);
		n1  = (px - cx) * (by - cy) - (bx - cx) * (py - cy);
		n2  = (ax - cx) * (py - cy) - (px - cx) * (ay - cy);
		n3  = (ax - px) * (by - py) - (bx - px) * (ay - py);
		res = '0;
		if (det == 0) begin
			res.degenerate = 1'b1;
			return res;
		end
		if (det < 0) begin
			det = -det; n1 = -n1; n2 = -n2; n3 = -n3;
		end
		floor_scaled(n1, det, q1, r1);
		floor_scaled(n2, det, q2, r2);
		floor_scaled(n3, det, q3, r3);
		// The three remainders add up to a whole multiple of the determinant.
		corr = det;
		q3 = q3 + (r1 + r2 + r3) / corr;
		sat = 1'b0;
		res.first  = clip_weight(q1, sat);
		res.second = clip_weight(q2, sat);
		res.third  = clip_weight(q3, sat);
		res.saturated = sat;
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [OUT_W-1:0] got,
		input logic [OUT_W-1:0] want);
		$display("mismatch on result %0d, %s: got %h, expected %h",
			words_checked, field, got, want);
		mismatch_count++;
	endtask

	task automatic add_query(input int px, input int py, input int ax, input int ay,
		input int bx, input int by, input int cx, input int cy);
		query_t w;
		w.px = COORD_BITS'(px); w.py = COORD_BITS'(py);
		w.ax = COORD_BITS'(ax); w.ay = COORD_BITS'(ay);
		w.bx = COORD_BITS'(bx); w.by = COORD_BITS'(by);
		w.cx = COORD_BITS'(cx); w.cy = COORD_BITS'(cy);
		w.drain = 0;
		pending_queries.push_back(w);
	endtask

	task automatic add_drain();
		query_t w;
		w = '{default: 0};
		w.drain = 1;
		pending_queries.push_back(w);
	endtask

	// Sender: bursts of random length separated by random gaps.
	int  burst_left = 0;
	int  gap_left = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (sent_last_edge)
				void'(pending_queries.pop_front());
			if (in_valid && !sent_last_edge) begin
				// Hold the word until it is taken.
			end else if (pending_queries.size() > 0 && pending_queries[0].drain) begin
				in_valid <= 1'b0;
				if (expected_weights.size() == 0)
					void'(pending_queries.pop_front());
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_queries.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				in_valid  <= 1'b1;
				point_x   <= pending_queries[0].px;
				point_y   <= pending_queries[0].py;
				vertex1_x <= pending_queries[0].ax;
				vertex1_y <= pending_queries[0].ay;
				vertex2_x <= pending_queries[0].bx;
				vertex2_y <= pending_queries[0].by;
				vertex3_x <= pending_queries[0].cx;
				vertex3_y <= pending_queries[0].cy;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: cycles through full speed, random stalls and long stalls.
	int rx_mode = 0;
	int rx_left = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode <= 0;
			rx_left <= 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= $urandom_range(0, 2);
				rx_left <= $urandom_range(5, 120);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				0: begin
					out_ready <= 1'b1;
				end
				1: begin
					out_ready <= ($urandom_range(0, 2) != 0);
				end
				default: begin
					out_ready <= (rx_left % 30 == 0);
				end
			endcase
		end
	end

	// Monitor: predict on input acceptance, check on output acceptance.
	always @(posedge clk) begin
		tbc_res_t exp_w;
		query_t   w;
		sent_last_edge <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				w.px = point_x; w.py = point_y;
				w.ax = vertex1_x; w.ay = vertex1_y;
				w.bx = vertex2_x; w.by = vertex2_y;
				w.cx = vertex3_x; w.cy = vertex3_y;
				w.drain = 0;
				expected_weights.push_back(barycentric_weights(w));
				words_sent++;
			end
			if (out_valid && out_ready) begin
				if (expected_weights.size() == 0) begin
					$display("unexpected result word %0d", words_checked);
					mismatch_count++;
				end else begin
					exp_w = expected_weights.pop_front();
					if (first_coord !== exp_w.first)
						report_mismatch("first_coord", first_coord, exp_w.first);
					if (second_coord !== exp_w.second)
						report_mismatch("second_coord", second_coord, exp_w.second);
					if (third_coord !== exp_w.third)
						report_mismatch("third_coord", third_coord, exp_w.third);
					if (degenerate !== exp_w.degenerate)
						report_mismatch("degenerate", degenerate, exp_w.degenerate);
					if (saturated !== exp_w.saturated)
						report_mismatch("saturated", saturated, exp_w.saturated);
					if (exp_w.degenerate)
						degenerate_seen++;
					if (exp_w.saturated)
						saturated_seen++;
				end
				words_checked++;
			end
			// Watchdog on cycles with no traffic on either side.
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int bx, by, dx, dy, k, sel;
		in_valid = 1'b0;
		out_ready = 1'b0;
		point_x = '0; point_y = '0; vertex1_x = '0; vertex1_y = '0;
		vertex2_x = '0; vertex2_y = '0; vertex3_x = '0; vertex3_y = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Point on each vertex, centroid, and the point outside the triangle.
		add_query(0, 0, 0, 0, 30, 0, 0, 30);
		add_query(30, 0, 0, 0, 30, 0, 0, 30);
		add_query(0, 30, 0, 0, 30, 0, 0, 30);
		add_query(10, 10, 0, 0, 30, 0, 0, 30);
		add_query(-50, 70, 0, 0, 30, 0, 0, 30);
		// Clockwise winding gives a negative determinant.
		add_query(10, 10, 0, 0, 0, 30, 30, 0);
		add_query(7, 3, 0, 0, 0, 30, 30, 0);
		// Zero area: all vertices equal, and three collinear vertices.
		add_query(5, 5, 9, 9, 9, 9, 9, 9);
		add_query(1, 2, 0, 0, 4, 4, 8, 8);
		add_query(-8388608, 8388607, 0, 0, 0, 0, 0, 0);
		// Coordinate extremes.
		add_query(8388607, 8388607, -8388608, -8388608, 8388607, -8388608,
			-8388608, 8388607);
		add_query(-8388608, -8388608, -8388608, -8388608, 8388607, -8388608,
			-8388608, 8388607);
		add_query(0, 0, 8388607, 8388607, -8388608, 8388607, 8388607, -8388608);
		// Tiny triangle with a far point clips the weights both ways.
		add_query(8388607, -8388608, 0, 0, 1, 0, 0, 1);
		add_query(-8388608, 8388607, 0, 0, 1, 0, 0, 1);
		add_query(8388607, 8388607, 0, 0, 1, 0, 0, 1);
		add_query(-8388608, -8388608, 0, 0, 0, 1, 1, 0);
		// Weights that the format cannot hold exactly, so each is a floor.
		add_query(1, 1, 0, 0, 3, 0, 0, 3);
		add_query(2, 1, -3, 0, 3, 0, 0, 7);
		add_drain();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			sel = $urandom_range(0, 9);
			bx = $urandom_range(0, 16777215) - 8388608;
			by = $urandom_range(0, 16777215) - 8388608;
			if (sel < 5) begin
				// Small triangle with the point near it.
				add_query(bx + $urandom_range(0, 600) - 300, by + $urandom_range(0, 600) - 300,
					bx + $urandom_range(0, 400) - 200, by + $urandom_range(0, 400) - 200,
					bx + $urandom_range(0, 400) - 200, by + $urandom_range(0, 400) - 200,
					bx + $urandom_range(0, 400) - 200, by + $urandom_range(0, 400) - 200);
			end else if (sel == 5) begin
				// Collinear vertices.
				dx = $urandom_range(0, 200) - 100;
				dy = $urandom_range(0, 200) - 100;
				k = $urandom_range(0, 6) - 3;
				add_query($urandom, $urandom, bx, by, bx + dx, by + dy,
					bx + k * dx, by + k * dy);
			end else if (sel == 6) begin
				// Point on one of the vertices.
				dx = $urandom_range(0, 2000) - 1000;
				dy = $urandom_range(0, 2000) - 1000;
				add_query(bx + dx, by + dy, bx, by, bx + dx, by + dy, bx + dy, by - dx);
			end else begin
				add_query($urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom);
			end
			if (i == RANDOM_WORDS / 2)
				add_drain();
		end

		wait (pending_queries.size() == 0 && expected_weights.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d result words of %0d sent: %0d zero-area, %0d clipped.",
			words_checked, words_sent, degenerate_seen, saturated_seen);
		$display("Covered vertex hits, both windings, extremes and random stalls.");
		if (mismatch_count == 0 && expected_weights.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
